### src/fscg_pkg.sv
`default_nettype none

package fscg_pkg;

    // Fixed-point format of positions, stops and strength (Q1.16, 1.0 = 65536)
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = FRAC_BITS + 1;
    localparam int CH_W      = 8;
    localparam int COLOR_W   = 3 * CH_W;
    localparam int SEG_W     = 2;

    localparam logic [POS_W-1:0] ONE       = POS_W'(1 << FRAC_BITS);
    localparam logic [POS_W-1:0] HALF      = POS_W'(1 << (FRAC_BITS - 1));
    localparam logic [POS_W-1:0] DEF_UPPER = POS_W'((33 * (1 << FRAC_BITS) + 50) / 100);
    localparam logic [POS_W-1:0] DEF_LOWER = POS_W'((66 * (1 << FRAC_BITS) + 50) / 100);

    // Divider: one quotient bit per step, f can reach ONE so FRAC_BITS+1 bits
    localparam int DIV_STEPS       = FRAC_BITS + 1;
    localparam int STEPS_PER_STAGE = 2;

    // APB register map
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_TOP_COLOR       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_UPPER_MID_COLOR = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOWER_MID_COLOR = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOTTOM_COLOR    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_UPPER_STOP      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LOWER_STOP      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BLEND_STRENGTH  = 3'd6;

    localparam logic [COLOR_W-1:0] RST_TOP_COLOR       = 24'h4B9FD1;
    localparam logic [COLOR_W-1:0] RST_UPPER_MID_COLOR = 24'h62B0D8;
    localparam logic [COLOR_W-1:0] RST_LOWER_MID_COLOR = 24'h78C0DF;
    localparam logic [COLOR_W-1:0] RST_BOTTOM_COLOR    = 24'hA9DCE8;

    // Segment codes
    localparam logic [SEG_W-1:0] SEG_UPPER  = 2'd0;
    localparam logic [SEG_W-1:0] SEG_MIDDLE = 2'd1;
    localparam logic [SEG_W-1:0] SEG_LOWER  = 2'd2;

    // Effective configuration: stops sanitized and sorted, strength clamped
    typedef struct packed {
        logic [COLOR_W-1:0] top_color;
        logic [COLOR_W-1:0] upper_mid_color;
        logic [COLOR_W-1:0] lower_mid_color;
        logic [COLOR_W-1:0] bottom_color;
        logic [POS_W-1:0]   s1;
        logic [POS_W-1:0]   s2;
        logic [POS_W-1:0]   strength;
    } cfg_t;

    // Segment stage -> divider
    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic             zero;
        logic [POS_W-1:0] n;
        logic [POS_W-1:0] span;
    } seg_item_t;

    // Divider -> color mix
    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [POS_W-1:0] frac;
    } frac_item_t;

endpackage

`default_nettype wire

### src/fscg_cfg.sv
`default_nettype none

module fscg_cfg
    import fscg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [COLOR_W-1:0] top_color_reg;
    logic [COLOR_W-1:0] upper_mid_color_reg;
    logic [COLOR_W-1:0] lower_mid_color_reg;
    logic [COLOR_W-1:0] bottom_color_reg;
    logic [POS_W-1:0]   upper_stop_reg;
    logic [POS_W-1:0]   lower_stop_reg;
    logic [POS_W-1:0]   blend_strength_reg;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [POS_W-1:0]     su;
    logic [POS_W-1:0]     sl;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_color_reg       <= RST_TOP_COLOR;
            upper_mid_color_reg <= RST_UPPER_MID_COLOR;
            lower_mid_color_reg <= RST_LOWER_MID_COLOR;
            bottom_color_reg    <= RST_BOTTOM_COLOR;
            upper_stop_reg      <= DEF_UPPER;
            lower_stop_reg      <= DEF_LOWER;
            blend_strength_reg  <= ONE;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TOP_COLOR:       top_color_reg       <= pwdata[COLOR_W-1:0];
                REG_UPPER_MID_COLOR: upper_mid_color_reg <= pwdata[COLOR_W-1:0];
                REG_LOWER_MID_COLOR: lower_mid_color_reg <= pwdata[COLOR_W-1:0];
                REG_BOTTOM_COLOR:    bottom_color_reg    <= pwdata[COLOR_W-1:0];
                REG_UPPER_STOP:      upper_stop_reg      <= pwdata[POS_W-1:0];
                REG_LOWER_STOP:      lower_stop_reg      <= pwdata[POS_W-1:0];
                REG_BLEND_STRENGTH:  blend_strength_reg  <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TOP_COLOR:       prdata = DATA_W'(top_color_reg);
            REG_UPPER_MID_COLOR: prdata = DATA_W'(upper_mid_color_reg);
            REG_LOWER_MID_COLOR: prdata = DATA_W'(lower_mid_color_reg);
            REG_BOTTOM_COLOR:    prdata = DATA_W'(bottom_color_reg);
            REG_UPPER_STOP:      prdata = DATA_W'(upper_stop_reg);
            REG_LOWER_STOP:      prdata = DATA_W'(lower_stop_reg);
            REG_BLEND_STRENGTH:  prdata = DATA_W'(blend_strength_reg);
            default:             prdata = '0;
        endcase
    end

    // Out-of-range stops fall back to defaults; smaller stop goes first
    always_comb
    begin
        su = (upper_stop_reg > ONE) ? DEF_UPPER : upper_stop_reg;
        sl = (lower_stop_reg > ONE) ? DEF_LOWER : lower_stop_reg;
        cfg.top_color       = top_color_reg;
        cfg.upper_mid_color = upper_mid_color_reg;
        cfg.lower_mid_color = lower_mid_color_reg;
        cfg.bottom_color    = bottom_color_reg;
        cfg.s1              = (su > sl) ? sl : su;
        cfg.s2              = (su > sl) ? su : sl;
        cfg.strength        = (blend_strength_reg > ONE) ? ONE : blend_strength_reg;
    end

endmodule

`default_nettype wire

### src/fscg_seg.sv
`default_nettype none

module fscg_seg
    import fscg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             in_valid,
    input  wire logic [POS_W-1:0] position,
    output logic                  up_ready,
    output logic                  out_valid,
    output seg_item_t             out_item,
    input  wire logic             down_ready
);

    logic             valid_reg;
    seg_item_t        item_reg;
    seg_item_t        item_next;
    logic             en;
    logic [POS_W-1:0] pos_sat;
    logic [POS_W-1:0] seg_start;
    logic [POS_W-1:0] seg_stop;

    assign en        = !valid_reg || down_ready;
    assign up_ready  = en;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // A position on a stop belongs to the earlier segment
    always_comb
    begin
        pos_sat = (position > ONE) ? ONE : position;
        if (pos_sat <= cfg.s1)
        begin
            item_next.seg = SEG_UPPER;
            seg_start     = '0;
            seg_stop      = cfg.s1;
        end
        else if (pos_sat <= cfg.s2)
        begin
            item_next.seg = SEG_MIDDLE;
            seg_start     = cfg.s1;
            seg_stop      = cfg.s2;
        end
        else
        begin
            item_next.seg = SEG_LOWER;
            seg_start     = cfg.s2;
            seg_stop      = ONE;
        end
        item_next.n    = pos_sat - seg_start;
        item_next.span = seg_stop - seg_start;
        item_next.zero = (item_next.span == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

### src/fscg_div.sv
`default_nettype none

module fscg_div
    import fscg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire seg_item_t in_item,
    output logic           up_ready,
    output logic           out_valid,
    output frac_item_t     out_item,
    input  wire logic      down_ready
);

    localparam int STAGES = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic             zero;
        logic [POS_W-1:0] span;
        logic [POS_W-1:0] rem;
        logic [POS_W-1:0] quo;
    } div_stage_t;

    // Restoring step; the first step tests n against span without a shift
    function automatic div_stage_t div_step(input div_stage_t x, input logic first);
        logic [POS_W:0] trial;
        logic           ge;
        div_stage_t     y;
        y     = x;
        trial = first ? {1'b0, x.rem} : {x.rem, 1'b0};
        ge    = (trial >= {1'b0, x.span});
        if (ge)
        begin
            trial = trial - {1'b0, x.span};
        end
        y.rem = trial[POS_W-1:0];
        y.quo = {x.quo[POS_W-2:0], ge};
        return y;
    endfunction

    div_stage_t       stage_reg [STAGES];
    logic             valid_reg [STAGES];
    div_stage_t       pipe_in   [STAGES];
    logic             pipe_in_v [STAGES];
    logic [STAGES:0]  en;
    div_stage_t       head;
    div_stage_t       last;

    always_comb
    begin
        head.seg  = in_item.seg;
        head.zero = in_item.zero;
        head.span = in_item.span;
        head.rem  = in_item.n;
        head.quo  = '0;
    end

    assign en[STAGES] = down_ready;
    assign up_ready   = en[0];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        div_stage_t stage_next;

        if (s == 0)
        begin : g_head
            assign pipe_in[s]   = head;
            assign pipe_in_v[s] = in_valid;
        end
        else
        begin : g_body
            assign pipe_in[s]   = stage_reg[s-1];
            assign pipe_in_v[s] = valid_reg[s-1];
        end

        assign en[s] = !valid_reg[s] || en[s+1];

        always_comb
        begin
            stage_next = pipe_in[s];
            for (int k = 0; k < STEPS_PER_STAGE; k++)
            begin
                if (s * STEPS_PER_STAGE + k < DIV_STEPS)
                begin
                    stage_next = div_step(stage_next, (s * STEPS_PER_STAGE + k) == 0);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en[s])
            begin
                valid_reg[s] <= pipe_in_v[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s] && pipe_in_v[s])
            begin
                stage_reg[s] <= stage_next;
            end
        end
    end

    // Zero-length segment gives f = 0, i.e. the segment's start color
    assign last          = stage_reg[STAGES-1];
    assign out_valid     = valid_reg[STAGES-1];
    assign out_item.seg  = last.seg;
    assign out_item.frac = last.zero ? '0 : ((last.quo > ONE) ? ONE : last.quo);

    // Segment stage must keep the numerator within the span
    a_num_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && up_ready |-> in_item.n <= in_item.span)
        else $error("divider numerator exceeds span");

    // With n <= span the quotient never needs the clamp
    a_quo_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last.zero |-> last.quo <= ONE)
        else $error("divider quotient above one");

    // Last stage holds its item while stalled
    a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STAGES-1] && !down_ready |=>
            valid_reg[STAGES-1] && $stable(stage_reg[STAGES-1]))
        else $error("divider lost or changed a stalled item");

endmodule

`default_nettype wire

### src/fscg_mix.sv
`default_nettype none

module fscg_mix
    import fscg_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cfg_t            cfg,
    input  wire logic            in_valid,
    input  wire frac_item_t      in_item,
    output logic                 up_ready,
    output logic                 out_valid,
    output logic     [CH_W-1:0]  red,
    output logic     [CH_W-1:0]  green,
    output logic     [CH_W-1:0]  blue,
    input  wire logic            out_stall
);

    localparam int MIX_W = CH_W + POS_W;

    // (a*(ONE-w) + b*w + ONE/2) >> FRAC_BITS, rounded half up
    function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b,
                                              input logic [POS_W-1:0] w);
        logic [POS_W-1:0] wc;
        logic [MIX_W-1:0] acc;
        wc  = ONE - w;
        acc = MIX_W'(a) * MIX_W'(wc) + MIX_W'(b) * MIX_W'(w) + MIX_W'(HALF);
        return acc[FRAC_BITS +: CH_W];
    endfunction

    // Channel 0 red, 1 green, 2 blue
    function automatic logic [CH_W-1:0] chan(input logic [COLOR_W-1:0] rgb, input int k);
        return rgb[COLOR_W-1-CH_W*k -: CH_W];
    endfunction

    logic               m1_valid_reg;
    logic [CH_W-1:0]    seg_chan_reg  [3];
    logic [CH_W-1:0]    seg_chan_next [3];
    logic               out_valid_reg;
    logic [CH_W-1:0]    out_chan_reg  [3];
    logic [CH_W-1:0]    out_chan_next [3];
    logic [COLOR_W-1:0] ca;
    logic [COLOR_W-1:0] cb;
    logic               en1;
    logic               en2;

    assign en2      = !out_valid_reg || !out_stall;
    assign en1      = !m1_valid_reg || en2;
    assign up_ready = en1;

    always_comb
    begin
        case (in_item.seg)
            SEG_UPPER:
            begin
                ca = cfg.top_color;
                cb = cfg.upper_mid_color;
            end
            SEG_MIDDLE:
            begin
                ca = cfg.upper_mid_color;
                cb = cfg.lower_mid_color;
            end
            default:
            begin
                ca = cfg.lower_mid_color;
                cb = cfg.bottom_color;
            end
        endcase
        for (int k = 0; k < 3; k++)
        begin
            seg_chan_next[k] = blend(chan(ca, k), chan(cb, k), in_item.frac);
        end
    end

    // Second pass pulls the segment color toward the flat top color
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            out_chan_next[k] = blend(chan(cfg.top_color, k), seg_chan_reg[k], cfg.strength);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                m1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                out_valid_reg <= m1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            seg_chan_reg <= seg_chan_next;
        end
        if (en2 && m1_valid_reg)
        begin
            out_chan_reg <= out_chan_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = out_chan_reg[0];
    assign green     = out_chan_reg[1];
    assign blue      = out_chan_reg[2];

endmodule

`default_nettype wire

### src/four_stop_color_gradient_core.sv
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ---------------------------------
// in        input      in_valid / in_stall  row_position[16:0], Q1.16
// out       output     out_valid/out_stall  red[7:0], green[7:0], blue[7:0]
// apb       slave      psel/penable/pready  paddr[4:0], pwdata/prdata[31:0]
//
// One transfer per clock sustained while out_stall is low; from input transfer
// to out_valid an item passes segment select, the divider stages and two color blends.
// The fraction divider forms 17 quotient bits at 2 per stage.
// Reset clears all pipeline valids and loads the register defaults.
// Each stage holds while it is full and the next one is stalled; empty stages
// still fill, so input transfers continue until the pipeline is full.
`default_nettype none

module four_stop_color_gradient_core
    import fscg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [POS_W-1:0]  row_position,

    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [CH_W-1:0]   red,
    output logic      [CH_W-1:0]   green,
    output logic      [CH_W-1:0]   blue,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    // Effective settings: sorted, range-checked stops and clamped strength
    cfg_t       cfg;

    logic       seg_up_ready;
    logic       seg_valid;
    seg_item_t  seg_item;
    logic       div_up_ready;
    logic       div_valid;
    frac_item_t div_item;
    logic       mix_up_ready;

    // Register file; the user must write it only while the pipeline is empty; the block does not enforce this
    fscg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage 1: saturate position, pick segment, form numerator and span
    fscg_seg u_seg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .position   (row_position),
        .up_ready   (seg_up_ready),
        .out_valid  (seg_valid),
        .out_item   (seg_item),
        .down_ready (div_up_ready)
    );

    // Stages 2-10: f = n * ONE / span, restoring division
    fscg_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (seg_valid),
        .in_item    (seg_item),
        .up_ready   (div_up_ready),
        .out_valid  (div_valid),
        .out_item   (div_item),
        .down_ready (mix_up_ready)
    );

    // Stages 11-12: segment interpolation, then strength blend (output reg)
    fscg_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (div_valid),
        .in_item   (div_item),
        .up_ready  (mix_up_ready),
        .out_valid (out_valid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_stall (out_stall)
    );

    assign in_stall = !seg_up_ready;

endmodule

`default_nettype wire

### test/gradient_color_checker.sv
`timescale 1ns / 100ps

module gradient_color_checker
    import fscg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [POS_W-1:0]  row_position,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [CH_W-1:0]   red,
    input  logic [CH_W-1:0]   green,
    input  logic [CH_W-1:0]   blue,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                pending,
    output int                mismatches
);

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } color_t;

    // shadow of the register file
    logic [COLOR_W-1:0] top_rgb;
    logic [COLOR_W-1:0] upper_mid_rgb;
    logic [COLOR_W-1:0] lower_mid_rgb;
    logic [COLOR_W-1:0] bottom_rgb;
    logic [POS_W-1:0]   upper_stop_q;
    logic [POS_W-1:0]   lower_stop_q;
    logic [POS_W-1:0]   strength_q;

    color_t expected_colors[$];
    int     fail_count = 0;

    // rounded linear interpolation, f in Q1.16
    function automatic longint unsigned lerp(input longint unsigned a, b, f);
        return (a * (64'(ONE) - f) + b * f + 64'(HALF)) >> FRAC_BITS;
    endfunction

    function automatic longint unsigned seg_fraction(input longint unsigned t, lo, hi);
        longint unsigned span;
        longint unsigned f;
        span = hi - lo;
        if (span == 0)
            return 0;
        f = ((t - lo) * 64'(ONE)) / span;
        return (f > 64'(ONE)) ? 64'(ONE) : f;
    endfunction

    function automatic color_t predict_color(input logic [POS_W-1:0] pos);
        longint unsigned    t, s1, s2, st, f, tmp, seg;
        logic [COLOR_W-1:0] c_a, c_b;
        logic [CH_W-1:0]    ch [3];
        color_t             rgb;
        t  = 64'((pos > ONE) ? ONE : pos);
        s1 = 64'((upper_stop_q > ONE) ? DEF_UPPER : upper_stop_q);
        s2 = 64'((lower_stop_q > ONE) ? DEF_LOWER : lower_stop_q);
        st = 64'((strength_q > ONE) ? ONE : strength_q);
        if (s1 > s2)
        begin
            tmp = s1;
            s1  = s2;
            s2  = tmp;
        end
        if (t <= s1)
        begin
            c_a = top_rgb;
            c_b = upper_mid_rgb;
            f   = seg_fraction(t, 64'd0, s1);
        end
        else if (t <= s2)
        begin
            c_a = upper_mid_rgb;
            c_b = lower_mid_rgb;
            f   = seg_fraction(t, s1, s2);
        end
        else
        begin
            c_a = lower_mid_rgb;
            c_b = bottom_rgb;
            f   = seg_fraction(t, s2, 64'(ONE));
        end
        for (int k = 0; k < 3; k++)
        begin
            seg   = lerp(64'(c_a[(23-8*k) -: 8]), 64'(c_b[(23-8*k) -: 8]), f);
            ch[k] = CH_W'(lerp(64'(top_rgb[(23-8*k) -: 8]), seg, st));
        end
        rgb.red   = ch[0];
        rgb.green = ch[1];
        rgb.blue  = ch[2];
        return rgb;
    endfunction

    task automatic check_field(input string name, input logic [CH_W-1:0] want, got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        color_t want;
        if (!rst_n)
        begin
            top_rgb       = RST_TOP_COLOR;
            upper_mid_rgb = RST_UPPER_MID_COLOR;
            lower_mid_rgb = RST_LOWER_MID_COLOR;
            bottom_rgb    = RST_BOTTOM_COLOR;
            upper_stop_q  = DEF_UPPER;
            lower_stop_q  = DEF_LOWER;
            strength_q    = ONE;
            expected_colors.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_TOP_COLOR:       top_rgb       = pwdata[COLOR_W-1:0];
                    REG_UPPER_MID_COLOR: upper_mid_rgb = pwdata[COLOR_W-1:0];
                    REG_LOWER_MID_COLOR: lower_mid_rgb = pwdata[COLOR_W-1:0];
                    REG_BOTTOM_COLOR:    bottom_rgb    = pwdata[COLOR_W-1:0];
                    REG_UPPER_STOP:      upper_stop_q  = pwdata[POS_W-1:0];
                    REG_LOWER_STOP:      lower_stop_q  = pwdata[POS_W-1:0];
                    REG_BLEND_STRENGTH:  strength_q    = pwdata[POS_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("unexpected color transfer %02h %02h %02h", red, green, blue);
                    fail_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    check_field("red", want.red, red);
                    check_field("green", want.green, green);
                    check_field("blue", want.blue, blue);
                end
            end
            if (in_valid && !in_stall)
                expected_colors.push_back(predict_color(row_position));
        end
        pending    <= expected_colors.size();
        mismatches <= fail_count;
    end

endmodule

### test/four_stop_color_gradient_core_tb.sv
`timescale 1ns / 100ps

module four_stop_color_gradient_core_tb;
    import fscg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 30;     // longer than an item needs to pass the pipeline
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 86;

    // address 28 decodes to no register
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID} stall_mode_e;

    logic clk = 1'b0;
    logic rst_n;

    logic              in_valid;
    logic              in_stall;
    logic [POS_W-1:0]  row_position;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CH_W-1:0]   red, green, blue;
    logic              psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int pending;
    int mismatches;

    // raw stop values of the current setting, used to aim positions at the edges
    logic [POS_W-1:0] stop_a_raw = DEF_UPPER;
    logic [POS_W-1:0] stop_b_raw = DEF_LOWER;

    stall_mode_e stall_mode = STALL_NONE;
    int          stall_left = 0;

    always #6 clk = ~clk;

    four_stop_color_gradient_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .row_position (row_position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // predicts every color and compares it with what comes out
    gradient_color_checker color_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .row_position (row_position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pending      (pending),
        .mismatches   (mismatches)
    );

    // Receiver back-pressure: stretches of random length, each with its own
    // character (free flow, light, heavy, or a solid block at its start).
    // Runs on its own, so stalls land on every phase of the sender's work.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_e'($urandom_range(0, 3));
            stall_left <= $urandom_range(4, 40);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= (stall_left > 20);
        endcase
    end

    // APB write: setup cycle, then access cycle until pready, then back to idle
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [DATA_W-1:0] top, upper_mid, lower_mid, bottom,
                             input logic [DATA_W-1:0] upper_stop, lower_stop, strength);
        write_reg(REG_TOP_COLOR, top);
        write_reg(REG_UPPER_MID_COLOR, upper_mid);
        write_reg(REG_LOWER_MID_COLOR, lower_mid);
        write_reg(REG_BOTTOM_COLOR, bottom);
        write_reg(REG_UPPER_STOP, upper_stop);
        write_reg(REG_LOWER_STOP, lower_stop);
        write_reg(REG_BLEND_STRENGTH, strength);
        stop_a_raw = upper_stop[POS_W-1:0];
        stop_b_raw = lower_stop[POS_W-1:0];
    endtask

    // one input transfer; valid stays high on return so a burst runs back to back
    task automatic push_position(input logic [POS_W-1:0] pos);
        in_valid     <= 1'b1;
        row_position <= pos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic hold_input(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // stop sending and wait for every predicted color to come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] random_color();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'h00FF_FFFF;
            default: return $urandom;   // upper byte junk, must be dropped
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_stop();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ONE;
            2:       return $urandom;   // often above 1.0 -> default stop
            default: return $urandom_range(0, ONE);
        endcase
    endfunction

    task automatic random_setup();
        logic [DATA_W-1:0] stop_a, stop_b, strength;
        stop_a = random_stop();
        stop_b = random_stop();
        if ($urandom_range(0, 7) == 0)
            stop_b = stop_a;            // coincident stops
        case ($urandom_range(0, 7))
            0:       strength = '0;
            1:       strength = ONE;
            2:       strength = $urandom;
            default: strength = $urandom_range(0, ONE);
        endcase
        configure(random_color(), random_color(), random_color(), random_color(),
                  stop_a, stop_b, strength);
    endtask

    function automatic logic [POS_W-1:0] random_position();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) == 1) ? ONE : '0;
            1:       return POS_W'($urandom_range(ONE + 1, (1 << POS_W) - 1));
            2:       return POS_W'(int'(stop_a_raw) + int'($urandom_range(0, 6)) - 3);
            3:       return POS_W'(int'(stop_b_raw) + int'($urandom_range(0, 6)) - 3);
            default: return POS_W'($urandom_range(0, ONE));
        endcase
    endfunction

    // Watchdog: ends the run once nothing has been accepted for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("four_stop_color_gradient_core_tb: errors");
        $finish;
    end

    initial
    begin : stimulus
        logic [POS_W-1:0] probes[$];
        int sent;
        int burst;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        row_position <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: stop edges, mid-range, both ends, positions past 1.0
        probes = '{17'd0, DEF_UPPER, DEF_UPPER + 17'd1, DEF_LOWER, DEF_LOWER + 17'd1,
                   17'd32768, ONE - 17'd1, ONE, ONE + 17'd1, 17'h1FFFF};
        foreach (probes[i])
            push_position(probes[i]);
        drain();

        // Stops written out of order, half strength; the unmapped write must not land
        configure(32'h0000_0000, 32'h00FF_FFFF, 32'h0000_0000, 32'h00FF_FFFF,
                  32'd50000, 32'd10000, 32'd32768);
        write_reg(REG_UNMAPPED, $urandom);
        probes = '{17'd0, 17'd10000, 17'd10001, 17'd50000, 17'd50001, ONE};
        foreach (probes[i])
            push_position(probes[i]);
        drain();

        // First segment of zero length, strength above 1.0 saturates
        configure(32'hFFFF_FFFF, 32'h0000_0000, 32'h00FF_FFFF, 32'h0000_0000,
                  32'd0, ONE, 32'h0001_FFFF);
        probes = '{17'd0, 17'd1, ONE};
        foreach (probes[i])
            push_position(probes[i]);
        drain();

        // Both stops above 1.0 fall back to defaults; zero strength gives flat top
        configure(random_color(), random_color(), random_color(), random_color(),
                  32'h0001_FFFF, 32'd70000, 32'd0);
        probes = '{DEF_UPPER, DEF_LOWER + 17'd1, ONE};
        foreach (probes[i])
            push_position(probes[i]);
        drain();

        // Random phases: new setting each phase, bursts with gaps of mixed length
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_setup();
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 32);
                for (int i = 0; i < burst && sent < PHASE_ITEMS; i++)
                begin
                    push_position(random_position());
                    sent++;
                end
                case ($urandom_range(0, 15))
                    0:       drain();   // let the pipeline run dry mid-phase
                    1, 2:    hold_input($urandom_range(5, 20));
                    3, 4, 5: ;          // keep streaming
                    default: hold_input($urandom_range(0, 3));
                endcase
            end
            drain();
        end

        // catch any stray transfer after the last expected color
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("four_stop_color_gradient_core_tb: clean");
        else
            $display("four_stop_color_gradient_core_tb: errors");
        $finish;
    end

endmodule
